// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/zowht_pkg.sv =====
package zowht_pkg;

    typedef enum logic [3:0] {
        CMD_REGISTER   = 4'd0,
        CMD_UNREGISTER = 4'd1,
        CMD_HIT        = 4'd2,
        CMD_BY_TASK    = 4'd3,
        CMD_FRONT      = 4'd4,
        CMD_COUNT      = 4'd5,
        CMD_NEXT_ABOVE = 4'd6,
        CMD_TOPMOST    = 4'd7,
        CMD_BACK       = 4'd8,
        CMD_READ_SLOT  = 4'd9
    } t_cmd;

    localparam logic signed [31:0] Z_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Z_MIN = 32'sh8000_0000;

    // Command as held in the queue between front and back.
    typedef struct packed {
        logic [3:0]         cmd;
        logic [15:0]        task_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic               can_close;
        logic signed [31:0] after_z;
        logic [3:0]         slot_index;
        logic               known;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [3:0]         slot;
        logic               slot_used;
        logic [15:0]        win_task;
        logic signed [15:0] win_x;
        logic signed [15:0] win_y;
        logic [14:0]        win_w;
        logic [14:0]        win_h;
        logic signed [31:0] win_z;
        logic               win_closable;
        logic [4:0]         used_count;
        logic               redraw;
    } t_result;

endpackage

// ===== design/zowht_front.sv =====
module zowht_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_command,
    input  logic [15:0]         i_task_id,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [14:0]         i_width,
    input  logic [14:0]         i_height,
    input  logic                i_can_close,
    input  logic signed [31:0]  i_after_z,
    input  logic [3:0]          i_slot_index,
    output logic                o_q_valid,
    input  logic                i_q_pop,
    output zowht_pkg::t_item    o_q_item
);
    // Two-entry queue; the known flag classifies the command at entry.
    zowht_pkg::t_item r_mem [2];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    zowht_pkg::t_item w_item;
    logic w_push;

    always_comb begin
        w_item            = '0;
        w_item.cmd        = i_command;
        w_item.task_id    = i_task_id;
        w_item.pos_x      = i_pos_x;
        w_item.pos_y      = i_pos_y;
        w_item.width      = i_width;
        w_item.height     = i_height;
        w_item.can_close  = i_can_close;
        w_item.after_z    = i_after_z;
        w_item.slot_index = i_slot_index;
        w_item.known      = (i_command <= zowht_pkg::CMD_READ_SLOT);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end
endmodule

// ===== design/zowht_back.sv =====
module zowht_back #(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  zowht_pkg::t_item    i_q_item,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output zowht_pkg::t_result  o_res
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SCAN2 = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    logic [SLOTS-1:0]   r_busy, n_busy;
    logic [15:0]        r_task [SLOTS];
    logic signed [15:0] r_x    [SLOTS];
    logic signed [15:0] r_y    [SLOTS];
    logic [14:0]        r_w    [SLOTS];
    logic [14:0]        r_h    [SLOTS];
    logic signed [31:0] r_z    [SLOTS];
    logic               r_cl   [SLOTS];
    logic signed [31:0] r_next_z;

    t_state             r_state;
    zowht_pkg::t_item   r_item;
    logic [IW-1:0]      r_idx;
    logic               r_best_ok;
    logic [IW-1:0]      r_best;
    logic signed [31:0] r_best_z;
    logic signed [31:0] r_min_z;
    logic [CW-1:0]      r_cnt;
    zowht_pkg::t_result r_res;
    logic               r_res_valid;

    // Current slot under the scan
    logic               w_busy;
    logic signed [31:0] w_z;
    logic signed [16:0] w_px, w_py, w_x0, w_y0;
    logic signed [17:0] w_x1, w_y1;
    logic               w_inside, w_take, w_last;
    logic signed [31:0] w_min_base;
    logic               w_out_fire;

    assign w_busy = r_busy[r_idx];
    assign w_z    = r_z[r_idx];
    assign w_px   = 17'(r_item.pos_x);
    assign w_py   = 17'(r_item.pos_y);
    assign w_x0   = 17'(r_x[r_idx]);
    assign w_y0   = 17'(r_y[r_idx]);
    assign w_x1   = 18'(w_x0) + 18'($signed({1'b0, r_w[r_idx]}));
    assign w_y1   = 18'(w_y0) + 18'($signed({1'b0, r_h[r_idx]}));
    assign w_inside = (w_px >= w_x0) && (18'(w_px) < w_x1)
                   && (w_py >= w_y0) && (18'(w_py) < w_y1);
    assign w_last = (32'(r_idx) == SLOTS - 1);
    assign w_min_base = (r_idx == '0) ? r_best_z : r_min_z;
    assign w_out_fire = (r_state == ST_OUT) && (!r_res_valid || i_res_ready);

    always_comb begin
        w_take = 1'b0;
        case (r_item.cmd)
            zowht_pkg::CMD_REGISTER:  w_take = !w_busy && !r_best_ok;
            zowht_pkg::CMD_UNREGISTER, zowht_pkg::CMD_BY_TASK,
            zowht_pkg::CMD_FRONT, zowht_pkg::CMD_BACK:
                w_take = w_busy && !r_best_ok && (r_task[r_idx] == r_item.task_id);
            zowht_pkg::CMD_HIT:
                w_take = w_busy && w_inside && (!r_best_ok || w_z > r_best_z);
            zowht_pkg::CMD_TOPMOST:
                w_take = w_busy && (!r_best_ok || w_z > r_best_z);
            zowht_pkg::CMD_NEXT_ABOVE:
                w_take = w_busy && (w_z > r_item.after_z) && (!r_best_ok || w_z < r_best_z);
            default: w_take = 1'b0;
        endcase
    end

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    logic               w_mod;
    logic signed [31:0] w_new_z;
    logic [IW-1:0]      w_rd;
    logic               w_rd_ok;
    zowht_pkg::t_result w_res;

    always_comb begin
        w_mod   = 1'b0;
        w_new_z = r_z[r_best];
        case (r_item.cmd)
            zowht_pkg::CMD_REGISTER, zowht_pkg::CMD_FRONT: begin
                w_mod = r_best_ok; w_new_z = r_next_z;
            end
            zowht_pkg::CMD_BACK: begin
                w_mod   = r_best_ok;
                w_new_z = (r_min_z > zowht_pkg::Z_MIN) ? r_min_z - 32'sd1 : zowht_pkg::Z_MIN;
            end
            zowht_pkg::CMD_UNREGISTER: w_mod = r_best_ok;
            default: w_mod = 1'b0;
        endcase
    end

    // Report stage reads the table after the update has been written.
    always_comb begin
        w_rd    = r_best;
        w_rd_ok = r_best_ok;
        if (r_item.cmd == zowht_pkg::CMD_READ_SLOT) begin
            w_rd    = r_item.slot_index[IW-1:0];
            w_rd_ok = (32'(r_item.slot_index) < SLOTS);
        end
        if (!r_item.known || r_item.cmd == zowht_pkg::CMD_COUNT) begin
            w_rd_ok = 1'b0;
        end
        w_res = '0;
        if (w_rd_ok) begin
            w_res.found        = 1'b1;
            w_res.slot         = 4'(w_rd);
            w_res.slot_used    = r_busy[w_rd];
            w_res.win_task     = r_task[w_rd];
            w_res.win_x        = r_x[w_rd];
            w_res.win_y        = r_y[w_rd];
            w_res.win_w        = r_w[w_rd];
            w_res.win_h        = r_h[w_rd];
            w_res.win_z        = r_z[w_rd];
            w_res.win_closable = r_cl[w_rd];
            w_res.redraw       = (r_item.cmd == zowht_pkg::CMD_REGISTER)
                              || (r_item.cmd == zowht_pkg::CMD_UNREGISTER)
                              || (r_item.cmd == zowht_pkg::CMD_FRONT)
                              || (r_item.cmd == zowht_pkg::CMD_BACK);
        end
        if (r_item.known && r_item.cmd == zowht_pkg::CMD_COUNT) begin
            w_res.used_count = 5'(r_cnt);
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (r_state == ST_APPLY && w_mod) begin
            if (r_item.cmd == zowht_pkg::CMD_REGISTER) n_busy[r_best] = 1'b1;
            if (r_item.cmd == zowht_pkg::CMD_UNREGISTER) n_busy[r_best] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= '0;
            r_next_z    <= 32'sd1;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_res_valid <= w_out_fire || (r_res_valid && !i_res_ready);
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_cnt     <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_busy) r_cnt <= r_cnt + 1'b1;
                    if (w_take) begin
                        r_best_ok <= 1'b1;
                        r_best    <= r_idx;
                        r_best_z  <= w_z;
                    end
                    if (w_last) begin
                        r_idx   <= '0;
                        r_state <= (r_item.cmd == zowht_pkg::CMD_BACK) ? ST_SCAN2 : ST_APPLY;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SCAN2: begin
                    // Lowest z of the busy slots, starting from the target's own z, for send to back.
                    r_min_z <= (w_busy && r_idx != r_best && w_z < w_min_base) ? w_z
                                                                             : w_min_base;
                    if (w_last) r_state <= ST_APPLY;
                    else r_idx <= r_idx + 1'b1;
                end
                ST_APPLY: begin
                    if (w_mod && (r_item.cmd == zowht_pkg::CMD_REGISTER
                               || r_item.cmd == zowht_pkg::CMD_FRONT)) begin
                        if (r_next_z != zowht_pkg::Z_MAX) r_next_z <= r_next_z + 32'sd1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) r_item <= i_q_item;
        if (w_out_fire) r_res <= w_res;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_task[k] <= '0; r_x[k] <= '0; r_y[k] <= '0; r_w[k] <= '0;
                r_h[k] <= '0; r_z[k] <= '0; r_cl[k] <= 1'b0;
            end
        end else if (r_state == ST_APPLY && w_mod) begin
            r_z[r_best] <= w_new_z;
            if (r_item.cmd == zowht_pkg::CMD_REGISTER) begin
                r_task[r_best] <= r_item.task_id;
                r_x[r_best]    <= r_item.pos_x;
                r_y[r_best]    <= r_item.pos_y;
                r_w[r_best]    <= r_item.width;
                r_h[r_best]    <= r_item.height;
                r_cl[r_best]   <= r_item.can_close;
            end
        end
    end
endmodule

// ===== design/z_ordered_window_hit_table.sv =====
// Window slot table with z-ordered hit testing.
// Input channel: i_valid/o_ready carry one command and its operands; every
// command yields exactly one result on o_valid/i_ready, in order.
// A two-entry queue separates the front, which takes and classifies
// commands, from the back, which scans the slot table one slot per cycle.
// Most commands take one scan of the table from acceptance to the result;
// send to back scans the table a second time for the lowest z. The back end
// takes a new command only once its result has gone into the result register;
// meanwhile the queue can hold up to two further commands.
// Reset clears every slot to zero and sets the next z value to one; the
// table is ready as soon as reset is released.
// When the receiver stalls the result register holds, the back end waits
// with its next result, and the queue fills before o_ready falls.
`include "assert_macros.svh"
module z_ordered_window_hit_table #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_command,
    input  logic [15:0]        i_task_id,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_width,
    input  logic [14:0]        i_height,
    input  logic               i_can_close,
    input  logic signed [31:0] i_after_z,
    input  logic [3:0]         i_slot_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic [3:0]         o_slot,
    output logic               o_slot_used,
    output logic [15:0]        o_win_task,
    output logic signed [15:0] o_win_x,
    output logic signed [15:0] o_win_y,
    output logic [14:0]        o_win_w,
    output logic [14:0]        o_win_h,
    output logic signed [31:0] o_win_z,
    output logic               o_win_closable,
    output logic [4:0]         o_used_count,
    output logic               o_redraw
);
    logic               w_q_valid, w_q_pop;
    zowht_pkg::t_item   w_q_item;
    zowht_pkg::t_result w_res;

    zowht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_command, .i_task_id, .i_pos_x, .i_pos_y, .i_width, .i_height,
        .i_can_close, .i_after_z, .i_slot_index,
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_item(w_q_item)
    );

    zowht_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_item(w_q_item),
        .o_res_valid(o_valid), .i_res_ready(i_ready), .o_res(w_res)
    );

    assign o_found        = w_res.found;
    assign o_slot         = w_res.slot;
    assign o_slot_used    = w_res.slot_used;
    assign o_win_task     = w_res.win_task;
    assign o_win_x        = w_res.win_x;
    assign o_win_y        = w_res.win_y;
    assign o_win_w        = w_res.win_w;
    assign o_win_h        = w_res.win_h;
    assign o_win_z        = w_res.win_z;
    assign o_win_closable = w_res.win_closable;
    assign o_used_count   = w_res.used_count;
    assign o_redraw       = w_res.redraw;

    `ASSERT_NEVER(a_redraw_found, i_clk, i_rst_n, o_valid && o_redraw && !o_found, "redraw without slot")
    `ASSERT_NEVER(a_count_found, i_clk, i_rst_n, o_valid && (o_used_count != 5'd0) && o_found, "count with found")
    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, !o_valid || (32'(o_used_count) <= SLOTS), "count too large")
endmodule
